FILE: rtl/core/vswc_pkg.sv
// ----------------------------------------------------------------------------
// vswc_pkg
// Shared types and constants of the valve schedule window controller.
// ----------------------------------------------------------------------------
package vswc_pkg;

  localparam int NumValvesDef  = 8;
  localparam int QueueDepthDef = 16;
  localparam int TimeW         = 31;
  localparam int MaxScan       = 8;

  localparam logic [3:0] ValvesReset = 4'd8;

  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdAdd   = 2'd1;
  localparam logic [1:0] CmdTick  = 2'd2;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef struct packed {
    logic             vol;
    logic [TimeW-1:0] dur;
    logic [TimeW-1:0] start;
  } win_t;

  typedef struct packed {
    logic        gt;
    logic [31:0] sum;
  } alu_res_t;

endpackage

FILE: rtl/core/vswc_alu.sv
// ----------------------------------------------------------------------------
// vswc_alu
// Shared adder and magnitude comparator used by the add-check, evaluate, sum, end and report steps.
// ----------------------------------------------------------------------------
module vswc_alu (
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  output vswc_pkg::alu_res_t res_o
);
  import vswc_pkg::*;

  assign res_o.gt  = a_i > b_i;
  assign res_o.sum = a_i + b_i;

endmodule

FILE: rtl/core/vswc_store.sv
// ----------------------------------------------------------------------------
// vswc_store
// Window memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vswc_store #(
  parameter int NUM_VALVES  = vswc_pkg::NumValvesDef,
  parameter int QUEUE_DEPTH = vswc_pkg::QueueDepthDef,
  localparam int VW = (NUM_VALVES > 1) ? $clog2(NUM_VALVES) : 1,
  localparam int IW = $clog2(QUEUE_DEPTH)
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [VW-1:0]  wv_i,
  input  logic [IW-1:0]  ws_i,
  input  vswc_pkg::win_t wdata_i,
  input  logic [VW-1:0]  rv_i,
  input  logic [IW-1:0]  rs_i,
  output vswc_pkg::win_t rdata_o
);
  import vswc_pkg::*;

  win_t mem_q [NUM_VALVES][QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wv_i][ws_i] <= wdata_i;
    end
    rdata_o <= mem_q[rv_i][rs_i];
  end

endmodule

FILE: rtl/core/valve_schedule_window_controller.sv
// An add runs an insertion walk that moves stored windows up one slot at a time
// through the window store, reading each one and writing it back one slot higher.
// A tick visits each scanned valve in turn and examines its head windows.
// One request at a time; busy is high until the last result has been issued.
// Results are strobed for one cycle and cannot be stalled.
// Reset clears all queues and valve states; valves_in_use resets to 8.
// ----------------------------------------------------------------------------
// valve_schedule_window_controller
// Sequencer over per-valve sorted window queues with one shared adder and
// comparator.
// ----------------------------------------------------------------------------
module valve_schedule_window_controller #(
  parameter int NUM_VALVES  = vswc_pkg::NumValvesDef,
  parameter int QUEUE_DEPTH = vswc_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic [1:0]  command_i,
  input  logic [2:0]  valve_index_i,
  input  logic [30:0] start_time_i,
  input  logic [30:0] duration_i,
  input  logic        window_mode_i,
  input  logic [30:0] current_time_i,
  output logic        res_valid_o,
  output logic        report_kind_o,
  output logic        add_ok_o,
  output logic [2:0]  report_valve_o,
  output logic        valve_open_o,
  output logic        state_changed_o,
  output logic [30:0] event_time_o,
  output logic        wake_valid_o,
  output logic [30:0] next_wake_o,
  output logic        last_report_o
);
  import vswc_pkg::*;

  localparam int VW = (NUM_VALVES > 1) ? $clog2(NUM_VALVES) : 1;
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int ScanLim = (NUM_VALVES < MaxScan) ? NUM_VALVES : MaxScan;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ADD_RD  = 9'b000000010,
    S_ADD_CHK = 9'b000000100,
    S_ADD_PUT = 9'b000001000,
    S_HEAD    = 9'b000010000,
    S_EVAL    = 9'b000100000,
    S_SUM     = 9'b001000000,
    S_END     = 9'b010000000,
    S_RPT     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]       viu_q;
  logic [CW-1:0]    cnt_q  [NUM_VALVES];
  logic [IW-1:0]    head_q [NUM_VALVES];
  logic [NUM_VALVES-1:0] open_q, known_q;
  logic [VW-1:0]    cv_q, cv_d;
  logic [2:0]       tv_q, tv_d;
  logic [3:0]       scan_q, scan_d, scan_now;
  logic [IW-1:0]    idx_q, idx_d;
  win_t             nw_q, nw_d;
  logic [TimeW-1:0] now_q, now_d;
  logic [31:0]      sum_q, sum_d;
  logic [TimeW-1:0] cand_q, cand_d;
  logic             cand_v_q, cand_v_d;
  logic             opn_q, opn_d;
  logic             wake_ok_q, wake_ok_d;
  logic [TimeW-1:0] wake_q, wake_d;

  logic             accept;
  logic             do_drop, do_inc, do_clear, do_rpt;
  logic [CW-1:0]    cnt_cur;
  logic [IW-1:0]    head_cur, rd_off, wr_off, rd_slot, wr_slot, head_nxt;
  logic             we;
  win_t             wdata, rdata;
  logic [31:0]      alu_a, alu_b;
  alu_res_t         alu_res;

  logic             o_valid_d, o_kind_d, o_ok_d, o_open_d, o_chg_d, o_wv_d, o_last_d;
  logic [2:0]       o_valve_d;
  logic [30:0]      o_evt_d, o_wake_d;

  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IW + 1)'(QUEUE_DEPTH)) begin
      s = s - (IW + 1)'(QUEUE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign cnt_cur  = cnt_q[cv_q];
  assign head_cur = head_q[cv_q];
  assign rd_off   = (state_q == S_ADD_RD) ? IW'(idx_q - IW'(1)) : '0;
  assign wr_off   = idx_q;
  assign rd_slot  = wrap_add(head_cur, rd_off);
  assign wr_slot  = wrap_add(head_cur, wr_off);
  assign head_nxt = wrap_add(head_cur, IW'(1));
  assign scan_now = (int'(viu_q) > ScanLim) ? 4'(ScanLim) : viu_q;

  always_comb begin
    alu_a = {1'b0, rdata.start};
    alu_b = {1'b0, now_q};
    case (state_q)
      S_ADD_CHK: alu_b = {1'b0, nw_q.start};
      S_SUM:     alu_b = {1'b0, rdata.dur};
      S_END: begin
        alu_a = sum_q;
        alu_b = {1'b0, now_q};
      end
      S_RPT: begin
        alu_a = {1'b0, wake_q};
        alu_b = {1'b0, cand_q};
      end
      default: ;
    endcase
  end

  vswc_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  vswc_store #(
    .NUM_VALVES  (NUM_VALVES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .wv_i    (cv_q),
    .ws_i    (wr_slot),
    .wdata_i (wdata),
    .rv_i    (cv_q),
    .rs_i    (rd_slot),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d   = state_q;
    cv_d      = cv_q;
    tv_d      = tv_q;
    scan_d    = scan_q;
    idx_d     = idx_q;
    nw_d      = nw_q;
    now_d     = now_q;
    sum_d     = sum_q;
    cand_d    = cand_q;
    cand_v_d  = cand_v_q;
    opn_d     = opn_q;
    wake_ok_d = wake_ok_q;
    wake_d    = wake_q;
    do_drop   = 1'b0;
    do_inc    = 1'b0;
    do_clear  = 1'b0;
    do_rpt    = 1'b0;
    we        = 1'b0;
    wdata     = nw_q;
    o_valid_d = 1'b0;
    o_kind_d  = 1'b0;
    o_ok_d    = 1'b0;
    o_valve_d = 3'd0;
    o_open_d  = 1'b0;
    o_chg_d   = 1'b0;
    o_evt_d   = '0;
    o_wv_d    = 1'b0;
    o_wake_d  = '0;
    o_last_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CmdClear: do_clear = 1'b1;
            CmdAdd: begin
              nw_d = '{vol: window_mode_i, dur: duration_i, start: start_time_i};
              if (int'(valve_index_i) < NUM_VALVES &&
                  int'(cnt_q[VW'(valve_index_i)]) < QUEUE_DEPTH) begin
                cv_d  = VW'(valve_index_i);
                idx_d = IW'(cnt_q[VW'(valve_index_i)]);
                state_d = (cnt_q[VW'(valve_index_i)] == '0) ? S_ADD_PUT : S_ADD_RD;
              end else begin
                o_valid_d = 1'b1;
                o_valve_d = valve_index_i;
                o_last_d  = 1'b1;
              end
            end
            CmdTick: begin
              if (scan_now != 4'd0) begin
                scan_d    = scan_now;
                cv_d      = '0;
                tv_d      = '0;
                wake_ok_d = 1'b0;
                wake_d    = '0;
                now_d     = current_time_i;
                state_d   = S_HEAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_ADD_RD: state_d = S_ADD_CHK;
      S_ADD_CHK: begin
        if (alu_res.gt) begin
          we      = 1'b1;
          wdata   = rdata;
          idx_d   = IW'(idx_q - IW'(1));
          state_d = (idx_q == IW'(1)) ? S_ADD_PUT : S_ADD_RD;
        end else begin
          state_d = S_ADD_PUT;
        end
      end
      S_ADD_PUT: begin
        we        = 1'b1;
        do_inc    = 1'b1;
        o_valid_d = 1'b1;
        o_ok_d    = 1'b1;
        o_valve_d = 3'(cv_q);
        o_last_d  = 1'b1;
        state_d   = S_IDLE;
      end
      S_HEAD: begin
        cand_v_d = 1'b0;
        opn_d    = 1'b0;
        state_d  = (cnt_cur == '0) ? S_RPT : S_EVAL;
      end
      S_EVAL: begin
        if (rdata.dur == '0) begin
          do_drop = 1'b1;
          state_d = S_HEAD;
        end else if (rdata.vol) begin
          state_d = S_RPT;
        end else if (alu_res.gt) begin
          cand_d   = rdata.start;
          cand_v_d = 1'b1;
          state_d  = S_RPT;
        end else begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        sum_d   = alu_res.sum;
        state_d = S_END;
      end
      S_END: begin
        if (!alu_res.gt) begin
          do_drop = 1'b1;
          state_d = S_HEAD;
        end else begin
          opn_d    = 1'b1;
          cand_d   = sum_q[31] ? TimeMax : sum_q[30:0];
          cand_v_d = 1'b1;
          state_d  = S_RPT;
        end
      end
      S_RPT: begin
        do_rpt = 1'b1;
        if (cand_v_q && (!wake_ok_q || alu_res.gt)) begin
          wake_ok_d = 1'b1;
          wake_d    = cand_q;
        end
        o_valid_d = 1'b1;
        o_kind_d  = 1'b1;
        o_valve_d = tv_q;
        o_open_d  = opn_q;
        o_chg_d   = known_q[cv_q] && (open_q[cv_q] != opn_q);
        o_evt_d   = now_q;
        o_wv_d    = wake_ok_d;
        o_wake_d  = wake_ok_d ? wake_d : '0;
        o_last_d  = ({1'b0, tv_q} + 4'd1 == scan_q);
        cv_d      = VW'(cv_q + VW'(1));
        tv_d      = tv_q + 3'd1;
        state_d   = o_last_d ? S_IDLE : S_HEAD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      viu_q       <= ValvesReset;
      open_q      <= '0;
      known_q     <= '0;
      cv_q        <= '0;
      tv_q        <= '0;
      scan_q      <= '0;
      wake_ok_q   <= 1'b0;
      cand_v_q    <= 1'b0;
      res_valid_o <= 1'b0;
      for (int i = 0; i < NUM_VALVES; i++) begin
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cv_q        <= cv_d;
      tv_q        <= tv_d;
      scan_q      <= scan_d;
      wake_ok_q   <= wake_ok_d;
      cand_v_q    <= cand_v_d;
      res_valid_o <= o_valid_d;
      if (cfg_we_i) begin
        viu_q <= cfg_wdata_i;
      end
      if (do_clear) begin
        for (int i = 0; i < NUM_VALVES; i++) begin
          cnt_q[i] <= '0;
        end
      end else if (do_inc) begin
        cnt_q[cv_q] <= CW'(cnt_cur + CW'(1));
      end else if (do_drop) begin
        cnt_q[cv_q]  <= CW'(cnt_cur - CW'(1));
        head_q[cv_q] <= head_nxt;
      end
      if (do_rpt) begin
        known_q[cv_q] <= 1'b1;
        open_q[cv_q]  <= opn_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q           <= idx_d;
    nw_q            <= nw_d;
    now_q           <= now_d;
    sum_q           <= sum_d;
    cand_q          <= cand_d;
    opn_q           <= opn_d;
    wake_q          <= wake_d;
    report_kind_o   <= o_kind_d;
    add_ok_o        <= o_ok_d;
    report_valve_o  <= o_valve_d;
    valve_open_o    <= o_open_d;
    state_changed_o <= o_chg_d;
    event_time_o    <= o_evt_d;
    wake_valid_o    <= o_wv_d;
    next_wake_o     <= o_wake_d;
    last_report_o   <= o_last_d;
  end

  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_report_o |-> !busy)
    else $error("Final report issued while the sequencer is still busy.");

  a_add_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !report_kind_o |-> last_report_o)
    else $error("Add status was not marked as the final report.");

  a_wake_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !wake_valid_o |-> next_wake_o == '0)
    else $error("Wake time reported without a pending wake.");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_cur) <= QUEUE_DEPTH)
    else $error("Queue count exceeds the queue depth.");

endmodule
